/* design/wsrx_pkg.sv */
// Shared types and constants for the WebSocket frame receiver.
// Used by every module of the block; depends on nothing.
`default_nettype none

package wsrx_pkg;

    localparam int LENGTH_WIDTH = 64;

    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_LF     = 8'h0a;
    localparam logic [6:0] LEN_CODE_16 = 7'h7e;
    localparam logic [6:0] LEN_CODE_64 = 7'h7f;

    localparam logic [3:0] EXT_BYTES_16 = 4'd2;
    localparam logic [3:0] EXT_BYTES_64 = 4'd8;
    localparam logic [3:0] KEY_BYTES    = 4'd4;

    typedef enum logic [5:0] {
        PH_HANDSHAKE = 6'b000001,
        PH_HDR0      = 6'b000010,
        PH_HDR1      = 6'b000100,
        PH_EXTLEN    = 6'b001000,
        PH_KEY       = 6'b010000,
        PH_PAYLOAD   = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        EV_OPEN  = 2'd0,
        EV_BYTE  = 2'd1,
        EV_EMPTY = 2'd2
    } t_event;

    typedef struct packed {
        t_event     kind;
        logic [7:0] payload_byte;
        logic       frame_final;
        logic [3:0] frame_opcode;
        logic       last_in_frame;
    } t_result;

endpackage

`default_nettype wire

/* design/wsrx_in_reg.sv */
// Input register stage of the WebSocket frame receiver.
// Holds one received byte until the parser takes it; uses wsrx_pkg.
`default_nettype none

module wsrx_in_reg
    import wsrx_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic       i_advance,
    output logic            o_in_stall,
    output logic            o_valid,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       open_slot;

    assign open_slot  = !r_valid || i_advance;
    assign o_in_stall = !open_slot;
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (open_slot) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (open_slot && i_in_valid) begin
            r_byte <= i_rx_byte;
        end
    end

endmodule

`default_nettype wire

/* design/wsrx_parser.sv */
// Parser state and per-byte update of the WebSocket frame receiver.
// Tracks the handshake terminator and the frame header; uses wsrx_pkg.
`default_nettype none

module wsrx_parser
    import wsrx_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output logic            o_res_valid,
    output t_result         o_res
);

    t_phase                  r_phase, n_phase;
    logic [1:0]              r_match, n_match;
    logic [3:0]              r_count, n_count;
    logic                    r_final, n_final;
    logic [3:0]              r_opcode, n_opcode;
    logic                    r_masked, n_masked;
    logic [LENGTH_WIDTH-1:0] r_len, n_len;
    logic [31:0]             r_key, n_key;
    logic [1:0]              r_pos, n_pos;

    logic [7:0]              want;
    logic [7:0]              key_byte;
    logic [LENGTH_WIDTH-1:0] len_after;
    logic                    use_after;

    always_comb begin
        case (r_pos)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_match  = r_match;
        n_count  = r_count;
        n_final  = r_final;
        n_opcode = r_opcode;
        n_masked = r_masked;
        n_len    = r_len;
        n_key    = r_key;
        n_pos    = r_pos;
        want     = r_match[0] ? CHAR_LF : CHAR_CR;
        len_after = r_len;
        use_after = 1'b0;
        o_res_valid = 1'b0;
        o_res = '{kind: EV_OPEN, payload_byte: 8'd0, frame_final: 1'b0,
                  frame_opcode: 4'd0, last_in_frame: 1'b0};

        case (r_phase)
            PH_HANDSHAKE: begin
                if (i_byte == want) begin
                    if (r_match == 2'd3) begin
                        n_match     = 2'd0;
                        n_phase     = PH_HDR0;
                        o_res_valid = 1'b1;
                    end else begin
                        n_match = r_match + 2'd1;
                    end
                end else begin
                    n_match = (i_byte == CHAR_CR) ? 2'd1 : 2'd0;
                end
            end
            PH_HDR1: begin
                n_masked = i_byte[7];
                if (i_byte[6:0] == LEN_CODE_16) begin
                    n_len   = '0;
                    n_count = EXT_BYTES_16;
                    n_phase = PH_EXTLEN;
                end else if (i_byte[6:0] == LEN_CODE_64) begin
                    n_len   = '0;
                    n_count = EXT_BYTES_64;
                    n_phase = PH_EXTLEN;
                end else begin
                    len_after = {{(LENGTH_WIDTH-7){1'b0}}, i_byte[6:0]};
                    n_len     = len_after;
                    use_after = 1'b1;
                end
            end
            PH_EXTLEN: begin
                len_after = {r_len[LENGTH_WIDTH-9:0], i_byte};
                n_len     = len_after;
                n_count   = r_count - 4'd1;
                use_after = (r_count == 4'd1);
            end
            PH_KEY: begin
                n_key   = {r_key[23:0], i_byte};
                n_count = r_count - 4'd1;
                if (r_count == 4'd1) begin
                    n_pos = 2'd0;
                    if (r_len == '0) begin
                        n_phase     = PH_HDR0;
                        o_res_valid = 1'b1;
                        o_res.kind  = EV_EMPTY;
                        o_res.frame_final   = r_final;
                        o_res.frame_opcode  = r_opcode;
                        o_res.last_in_frame = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_pos       = r_pos + 2'd1;
                n_len       = r_len - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
                o_res_valid = 1'b1;
                o_res.kind  = EV_BYTE;
                o_res.payload_byte  = r_masked ? (i_byte ^ key_byte) : i_byte;
                o_res.frame_final   = r_final;
                o_res.frame_opcode  = r_opcode;
                o_res.last_in_frame = (r_len == {{(LENGTH_WIDTH-1){1'b0}}, 1'b1});
                if (o_res.last_in_frame) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                n_final  = i_byte[7];
                n_opcode = i_byte[3:0];
                n_phase  = PH_HDR1;
            end
        endcase

        if (use_after) begin
            if (n_masked) begin
                n_key   = '0;
                n_count = KEY_BYTES;
                n_phase = PH_KEY;
            end else begin
                n_pos = 2'd0;
                if (len_after == '0) begin
                    n_phase     = PH_HDR0;
                    o_res_valid = 1'b1;
                    o_res.kind  = EV_EMPTY;
                    o_res.frame_final   = r_final;
                    o_res.frame_opcode  = r_opcode;
                    o_res.last_in_frame = 1'b1;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HANDSHAKE;
            r_match  <= 2'd0;
            r_count  <= 4'd0;
            r_final  <= 1'b0;
            r_opcode <= 4'd0;
            r_masked <= 1'b0;
            r_len    <= '0;
            r_key    <= 32'd0;
            r_pos    <= 2'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_match  <= n_match;
            r_count  <= n_count;
            r_final  <= n_final;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_key    <= n_key;
            r_pos    <= n_pos;
        end
    end

endmodule

`default_nettype wire

/* design/wsrx_out_reg.sv */
// Result register of the WebSocket frame receiver.
// Holds one result until the downstream side takes it; uses wsrx_pkg.
`default_nettype none

module wsrx_out_reg
    import wsrx_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_step,
    input  wire logic    i_res_valid,
    input  wire t_result i_res,
    input  wire logic    i_out_stall,
    output logic         o_advance,
    output logic         o_out_valid,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_advance   = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_step && i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_step && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

/* design/websocket_frame_receiver.sv */
// WebSocket frame receiver, client receive direction.
// Takes one received byte per transaction on the input channel (i_in_valid,
// o_in_stall, i_rx_byte) and gives at most one result per byte on the output
// channel (o_out_valid, i_out_stall and the result fields).
// After reset the block scans for the CR LF CR LF that ends the HTTP upgrade
// reply and reports it with a handshake-complete result. It then parses
// frames and gives one result per payload byte, unmasked, or one empty-frame
// result for a frame without payload, on its last header or key byte. Other
// header and key bytes give no result. A byte is captured in the input
// register, and the parser result is registered in the result register.
// Throughput is one byte per cycle while the output channel does not stall.
// When the output stalls with the result register full, it holds its contents
// and the input register takes one more byte if empty; o_in_stall then rises.
// Reset (synchronous, active low) empties both registers and returns the
// parser to the handshake scan. Depends on wsrx_pkg and the wsrx_ modules.
`default_nettype none

module websocket_frame_receiver
    import wsrx_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_event_kind,
    output logic [7:0]      o_payload_byte,
    output logic            o_frame_final,
    output logic [3:0]      o_frame_opcode,
    output logic            o_last_in_frame
);

    logic       advance;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       step;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign step = in_valid && advance;

    wsrx_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .i_advance  (advance),
        .o_in_stall (o_in_stall),
        .o_valid    (in_valid),
        .o_byte     (in_byte)
    );

    wsrx_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsrx_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_event_kind    = out_res.kind;
    assign o_payload_byte  = out_res.payload_byte;
    assign o_frame_final   = out_res.frame_final;
    assign o_frame_opcode  = out_res.frame_opcode;
    assign o_last_in_frame = out_res.last_in_frame;

`ifndef NO_ASSERTIONS
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_kind == EV_OPEN || o_event_kind == EV_BYTE ||
                         o_event_kind == EV_EMPTY))
        else $error("result carries an undefined event kind");

    a_open_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_kind == EV_OPEN) |->
            (o_payload_byte == 8'd0 && !o_frame_final && o_frame_opcode == 4'd0 &&
             !o_last_in_frame))
        else $error("handshake result carries frame fields");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_kind == EV_EMPTY) |->
            (o_last_in_frame && o_payload_byte == 8'd0))
        else $error("empty-frame result is not marked last");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while the result register can move");
`endif

endmodule

`default_nettype wire
